// ===== design/flpf_pkg.sv =====
package flpf_pkg;

  // stream widths, fields packed from bit 0 up and padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;
  localparam int POS_W       = 10;
  localparam int LEN_W       = 10;

  // fixed frame layout
  localparam int DATA_START = 18;
  localparam int SUM_START  = 6;

  localparam logic [7:0] HEAD_A  = 8'hFC;
  localparam logic [7:0] HEAD_B  = 8'hA1;
  localparam logic [7:0] TYPE_B  = 8'hA5;
  localparam logic [7:0] PAD_B   = 8'hAA;
  localparam logic [7:0] TAIL_A  = 8'h1E;
  localparam logic [7:0] TAIL_B  = 8'h1B;

  // what the back end puts on the wire for one slot
  localparam logic [1:0] SEL_BYTE   = 2'd0;
  localparam logic [1:0] SEL_SUM_HI = 2'd1;
  localparam logic [1:0] SEL_SUM_LO = 2'd2;

  typedef struct packed {
    logic [7:0] byte_val;
    logic [1:0] sel;
    logic       taken;
    logic       last;
    logic       err;
    logic       sum_clr;
    logic       sum_en;
  } slot_t;

endpackage

// ===== design/fixed_length_packet_framer_core.sv =====
// Fixed-length packet framer. Each accepted input item is one wire slot and
// yields exactly one output item, so a frame of 24 + PAYLOAD_BYTES items
// (886 at the default) goes out as FC FC A1 A1, index[15:0], A5 A5, total,
// index, length, the data field, a 16-bit checksum and 1E 1B 1E 1B, all
// big endian. The item at frame start samples the payload length, packet
// number and packet count; a length above PAYLOAD_BYTES is rejected with a
// zero byte and length_error, and the framer stays at frame start. Data slots
// below the sampled length emit payload_byte and flag payload_taken, later
// ones emit AA padding. The checksum is the wrapping byte sum from the type
// field through the last data byte. Throughput is one item per clock while
// neither side stalls; an accepted item is written to the queue, then moves
// through the checksum stage into the output register, from which it leaves.
// A two-entry queue between the slot decoder and the checksum stage, plus
// the output register, lets either side stall on its own.
module fixed_length_packet_framer_core import flpf_pkg::*; #(
  parameter int PAYLOAD_BYTES = 862
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: payload_byte[7:0], payload_length[17:8], pkt_number[49:18],
  // pkt_count[81:50], zero pad [87:82]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: wire_byte[7:0]
  // out_tuser: payload_taken[0], length_error[1]
  // out_tlast: last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  // classified slots from decoder to checksum stage
  slot_t q_in, q_head;
  logic  q_push, q_ready, q_valid, q_pop;

  // slot decoder: tracks frame position, samples packet fields
  flpf_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // short decoupling queue
  flpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // checksum accumulator and output register
  flpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/flpf_front.sv =====
module flpf_front import flpf_pkg::*; #(
  parameter int PAYLOAD_BYTES = 862
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  q_ready,
  output logic                  q_push,
  output slot_t                 q_entry
);

  localparam int DATA_END    = DATA_START + PAYLOAD_BYTES;
  localparam int FRAME_BYTES = DATA_END + 6;

  localparam logic [POS_W:0]   FRAME_C    = (POS_W+1)'(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_C     = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] DEND_C     = POS_W'(DATA_END);
  localparam logic [POS_W-1:0] DSTART_C   = POS_W'(DATA_START);
  localparam logic [POS_W-1:0] SSTART_C   = POS_W'(SUM_START);
  localparam logic [LEN_W-1:0] MAXLEN_C   = LEN_W'(PAYLOAD_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      hidx_r, htot_r;
  logic [LEN_W-1:0] hlen_r;

  logic [7:0]       pay;
  logic [LEN_W-1:0] len;
  logic [31:0]      idx, tot;
  logic [POS_W-1:0] p, doff;
  logic             reject;
  slot_t            ent;

  assign pay = in_tdata[7:0];
  assign len = in_tdata[17:8];
  assign idx = in_tdata[49:18];
  assign tot = in_tdata[81:50];

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;
  assign q_entry   = ent;

  always_comb begin
    p      = ({1'b0, pos_r} >= FRAME_C) ? '0 : pos_r;
    doff   = p - DSTART_C;
    reject = (p == '0) && (len > MAXLEN_C);
    ent          = '0;
    ent.sel      = SEL_BYTE;
    ent.sum_clr  = (p == '0) && !reject;
    ent.sum_en   = (p >= SSTART_C) && (p < DEND_C);
    pos_nxt      = p + 1'b1;
    priority if (reject) begin
      ent.err = 1'b1;
      pos_nxt = '0;
    end else if (p < 10'd2) begin
      ent.byte_val = HEAD_A;
    end else if (p < 10'd4) begin
      ent.byte_val = HEAD_B;
    end else if (p < 10'd6) begin
      ent.byte_val = p[0] ? hidx_r[7:0] : hidx_r[15:8];
    end else if (p < 10'd8) begin
      ent.byte_val = TYPE_B;
    end else if (p < 10'd12) begin
      ent.byte_val = htot_r[8*(3-p[1:0]) +: 8];
    end else if (p < 10'd16) begin
      ent.byte_val = hidx_r[8*(3-p[1:0]) +: 8];
    end else if (p < DSTART_C) begin
      ent.byte_val = p[0] ? hlen_r[7:0] : {6'd0, hlen_r[9:8]};
    end else if (p < DEND_C) begin
      if (doff < hlen_r) begin
        ent.byte_val = pay;
        ent.taken    = 1'b1;
      end else begin
        ent.byte_val = PAD_B;
      end
    end else if (p == DEND_C) begin
      ent.sel = SEL_SUM_HI;
    end else if (p == DEND_C + 1'b1) begin
      ent.sel = SEL_SUM_LO;
    end else begin
      ent.byte_val = (p[0] ^ DEND_C[0]) ? TAIL_B : TAIL_A;
      if (p == LAST_C) begin
        ent.last = 1'b1;
        pos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

  // sampled packet fields, always loaded at a frame start before any use
  always_ff @(posedge clk) begin
    if (q_push && (p == '0) && !reject) begin
      hidx_r <= idx;
      htot_r <= tot;
      hlen_r <= len;
    end
  end

`ifndef SYNTH
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < FRAME_C)
    else $error("frame position past frame end");
`endif

endmodule

// ===== design/flpf_queue.sv =====
module flpf_queue import flpf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  slot_t push_entry,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output slot_t head
);

  slot_t      mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign ready = (cnt_r != 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from empty queue");
`endif

endmodule

// ===== design/flpf_back.sv =====
module flpf_back import flpf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  slot_t                  q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  logic [15:0] sum_r, sum_nxt, sum_base;
  logic [7:0]  byte_out;
  logic        vld_r;
  logic [7:0]  data_r;
  logic        taken_r, last_r, err_r;

  assign q_pop = q_valid && (!vld_r || out_tready);

  always_comb begin
    sum_base = q_head.sum_clr ? 16'd0 : sum_r;
    unique case (q_head.sel)
      SEL_SUM_HI: byte_out = sum_base[15:8];
      SEL_SUM_LO: byte_out = sum_base[7:0];
      default:    byte_out = q_head.byte_val;
    endcase
    sum_nxt = q_head.sum_en ? (sum_base + {8'd0, byte_out}) : sum_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sum_r <= '0;
    end else begin
      if (q_pop) begin
        vld_r <= 1'b1;
        sum_r <= sum_nxt;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r  <= byte_out;
      taken_r <= q_head.taken;
      last_r  <= q_head.last;
      err_r   <= q_head.err;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {err_r, taken_r};
  assign out_tlast  = last_r;

`ifndef SYNTH
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && err_r) |-> (data_r == 8'd0 && !last_r && !taken_r))
    else $error("rejected start carries data or flags");
  a_last_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && last_r) |-> !taken_r)
    else $error("tail byte marked as payload");
`endif

endmodule
